/* design/nbm_pkg.sv */
// nbm_pkg: shared types, character codes and decode functions for the
// nested bracket matcher; no dependencies
package nbm_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int PAIR_W          = 31;
    localparam int CHAR_W          = 8;

    localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_END = 8'd35;
    localparam logic [CHAR_W-1:0] CH_RO  = 8'd40;
    localparam logic [CHAR_W-1:0] CH_RC  = 8'd41;
    localparam logic [CHAR_W-1:0] CH_SO  = 8'd91;
    localparam logic [CHAR_W-1:0] CH_SC  = 8'd93;
    localparam logic [CHAR_W-1:0] CH_BO  = 8'd123;
    localparam logic [CHAR_W-1:0] CH_BC  = 8'd125;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_ROUND  = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_BRACE  = 2'd3;

    typedef struct packed {
        logic              all_matched;
        logic [PAIR_W-1:0] pair_count;
    } result_t;

    // kind of an opening bracket, none for anything else
    function automatic kind_t open_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        unique case (c)
            CH_RO:   k = KIND_ROUND;
            CH_SO:   k = KIND_SQUARE;
            CH_BO:   k = KIND_BRACE;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of a closing bracket, none for anything else
    function automatic kind_t close_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        unique case (c)
            CH_RC:   k = KIND_ROUND;
            CH_SC:   k = KIND_SQUARE;
            CH_BC:   k = KIND_BRACE;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

/* design/nbm_stack_mem.sv */
// nbm_stack_mem: kind stack storage, one write port and one registered read port
// depends on nbm_pkg
module nbm_stack_mem #(
    parameter int STACK_DEPTH = nbm_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  nbm_pkg::kind_t      wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output nbm_pkg::kind_t      rd_data
);

    nbm_pkg::kind_t mem [STACK_DEPTH];
    nbm_pkg::kind_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/nbm_ctrl.sv */
// nbm_ctrl: per-character bracket checking with top-of-stack register,
// depth, pair count and error flag; drives the stack memory; depends on nbm_pkg
module nbm_ctrl #(
    parameter int STACK_DEPTH = nbm_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STACK_DEPTH),
    parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [nbm_pkg::CHAR_W-1:0]  char_code,
    // stack memory
    output logic                        mem_wr_en,
    output logic [ADDR_W-1:0]           mem_wr_addr,
    output nbm_pkg::kind_t              mem_wr_data,
    output logic [ADDR_W-1:0]           mem_rd_addr,
    input  nbm_pkg::kind_t              mem_rd_data,
    // result on end of string
    output logic                        res_valid,
    output nbm_pkg::result_t            res,
    output logic [DEPTH_W-1:0]          depth
);

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);

    logic [DEPTH_W-1:0]         depth_reg, depth_next;
    nbm_pkg::kind_t             top_reg, top_next;
    logic [nbm_pkg::PAIR_W-1:0] pairs_reg, pairs_next;
    logic                       err_reg, err_next;
    nbm_pkg::kind_t             ok, ck;
    logic [DEPTH_W-1:0]         rd_ptr;

    assign ok = nbm_pkg::open_kind(char_code);
    assign ck = nbm_pkg::close_kind(char_code);

    always_comb begin
        depth_next  = depth_reg;
        top_next    = top_reg;
        pairs_next  = pairs_reg;
        err_next    = err_reg;
        mem_wr_en   = 1'b0;
        res_valid   = 1'b0;
        res.all_matched = !err_reg && (depth_reg == '0);
        res.pair_count  = pairs_reg;
        if (in_fire) begin
            if (char_code == nbm_pkg::CH_END) begin
                res_valid  = 1'b1;
                depth_next = '0;
                top_next   = nbm_pkg::KIND_NONE;
                pairs_next = '0;
                err_next   = 1'b0;
            end else if (!err_reg) begin
                if (ok != nbm_pkg::KIND_NONE) begin
                    if (depth_reg == DEPTH_FULL ||
                        (depth_reg != '0 && ok > top_reg)) begin
                        err_next = 1'b1;
                    end else begin
                        mem_wr_en  = 1'b1;
                        depth_next = depth_reg + DEPTH_ONE;
                        top_next   = ok;
                    end
                end else if (ck != nbm_pkg::KIND_NONE) begin
                    if (depth_reg == '0 || ck != top_reg) begin
                        err_next = 1'b1;
                    end else begin
                        depth_next = depth_reg - DEPTH_ONE;
                        // entry under the top was fetched last cycle
                        top_next   = (depth_reg > DEPTH_ONE) ? mem_rd_data
                                                             : nbm_pkg::KIND_NONE;
                        if (pairs_reg != nbm_pkg::PAIR_MAX) begin
                            pairs_next = pairs_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // prefetch the entry under the next top
    assign rd_ptr      = (depth_next >= DEPTH_TWO) ? depth_next - DEPTH_TWO : '0;
    assign mem_rd_addr = rd_ptr[ADDR_W-1:0];
    assign mem_wr_addr = depth_reg[ADDR_W-1:0];
    assign mem_wr_data = ok;
    assign depth       = depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            top_reg   <= nbm_pkg::KIND_NONE;
            pairs_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            top_reg   <= top_next;
            pairs_reg <= pairs_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* design/nbm_out_buf.sv */
// nbm_out_buf: output register with a skid stage for result beats
// depends on nbm_pkg
module nbm_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  nbm_pkg::result_t in_res,
    output logic             in_ready,
    output logic             out_valid,
    output nbm_pkg::result_t out_res,
    input  logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    nbm_pkg::result_t out_res_reg, out_res_next;
    nbm_pkg::result_t skid_res_reg, skid_res_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* design/nested_bracket_matcher.sv */
// nested_bracket_matcher: top level, bracket checker over a character stream
// depends on nbm_pkg, nbm_stack_mem, nbm_ctrl, nbm_out_buf
//
// Takes one character beat per cycle while s_ready is high and checks that the
// brackets (), [] and {} of each string are balanced and properly nested:
// braces may hold any kind, square brackets hold square and round, round
// brackets hold only round. Every other character except '#' is ignored. A '#'
// ends the string and yields one result beat: m_all_matched is 1 when no error
// occurred and no bracket is left open, and m_pair_count gives the pairs closed
// before the first error, saturating at its all-ones value. A mismatched
// closer, a closer on an empty stack, a forbidden nesting (flagged when the
// opener arrives) or an opener with STACK_DEPTH brackets already open marks the
// string as failed and freezes the count until '#'. The kinds of open brackets
// live in a STACK_DEPTH-entry memory with one write and one registered read
// port, the top kind is held in a register and the entry just below it is
// prefetched every cycle, so a pop finds the new top already read. Result beats
// pass through an output register plus a skid stage; s_ready drops only while
// both hold an untaken result. No clearing pass is needed after reset: only
// entries pushed in the current string are read.
module nested_bracket_matcher #(
    parameter int STACK_DEPTH = nbm_pkg::STACK_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // character beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nbm_pkg::CHAR_W-1:0]        s_char_code,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_all_matched,
    output logic [nbm_pkg::PAIR_W-1:0]        m_pair_count
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    logic               in_fire;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ADDR_W-1:0]  mem_rd_addr;
    nbm_pkg::kind_t     mem_wr_data;
    nbm_pkg::kind_t     mem_rd_data;
    logic               res_valid;
    nbm_pkg::result_t   res;
    nbm_pkg::result_t   out_res;
    logic [DEPTH_W-1:0] depth;

    // a character is taken whenever s_valid is high and the result path has room
    assign in_fire = s_valid && s_ready;

    // open bracket kinds, one entry per nesting level
    nbm_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // matching logic: top register, depth, pair count, error flag
    nbm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W),
        .DEPTH_W     (DEPTH_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .char_code   (s_char_code),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .depth       (depth)
    );

    // result register and skid stage
    nbm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_res   (out_res),
        .out_ready (m_ready)
    );

    assign m_all_matched = out_res.all_matched;
    assign m_pair_count  = out_res.pair_count;

    // the stack never holds more than its depth
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

    // an end of string always leaves a result beat presented next cycle
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_char_code == nbm_pkg::CH_END) |=> m_valid)
        else $error("end of string produced no result");

    // end of string clears the stack
    a_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_char_code == nbm_pkg::CH_END) |=> depth == '0)
        else $error("stack not cleared after end of string");

endmodule
